/* design/spba_pkg.sv */
// Shared types, codes and defaults for the staging pool bump allocator.
package spba_pkg;

  localparam int SIZE_W = 29;
  localparam int CMD_W = 2;
  localparam int BIDX_W = 3;
  localparam int STATUS_W = 3;
  localparam int USE_W = 4;

  localparam logic [SIZE_W-1:0] POOL_RESET = 29'd268435456;

  localparam int DEF_MAX_BUFFERS = 8;
  localparam longint unsigned DEF_MAX_LIVE = 64'd65535;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_LIVE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd5;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FREE,
    OP_INIT
  } op_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] req;
    logic [SIZE_W-1:0] pool;
    logic [SIZE_W:0]   fend;
  } cell_ctl_t;

  // Status of one cell back to the controller.
  typedef struct packed {
    logic              hit;
    logic              miss;
    logic              empty;
    logic [SIZE_W-1:0] offset;
  } cell_sts_t;

endpackage

/* design/spba_if.sv */
// Valid/ready channel interfaces for allocator requests and results.
interface spba_in_if import spba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SIZE_W-1:0] req_size;
  logic [BIDX_W-1:0] free_buffer;
  logic [SIZE_W-1:0] free_offset;
  logic [SIZE_W-1:0] free_length;

  modport source (output valid, cmd, req_size, free_buffer, free_offset, free_length,
                  input ready);
  modport sink (input valid, cmd, req_size, free_buffer, free_offset, free_length,
                output ready);
endinterface

interface spba_out_if import spba_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BIDX_W-1:0]   buffer_index;
  logic [SIZE_W-1:0]   alloc_offset;
  logic [USE_W-1:0]    buffers_in_use;

  modport source (output valid, status, buffer_index, alloc_offset, buffers_in_use,
                  input ready);
  modport sink (input valid, status, buffer_index, alloc_offset, buffers_in_use,
                output ready);
endinterface

/* design/spba_cell.sv */
// One buffer cell: bump offset, freed mark and live count, with a search token stage.
module spba_cell import spba_pkg::*; #(
  parameter int              LIVE_W   = 16,
  parameter longint unsigned MAX_LIVE = DEF_MAX_LIVE
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      sel,
  input  logic      open_bit,
  input  logic      tok_in,
  output logic      tok_out,
  output cell_sts_t sts
);

  logic [SIZE_W-1:0] bump;
  logic [SIZE_W-1:0] freed;
  logic [LIVE_W-1:0] live;

  logic [SIZE_W:0] sum;
  logic            full;
  logic            fit_bump;
  logic            fit_wrap;
  logic            active;
  logic            hit;

  assign sum      = {1'b0, bump} + {1'b0, ctl.req};
  assign full     = live >= LIVE_W'(MAX_LIVE);
  assign fit_bump = sum <= {1'b0, ctl.pool};
  assign fit_wrap = freed >= ctl.req;
  assign active   = tok_in && open_bit;
  assign hit      = active && !full && (fit_bump || fit_wrap);

  always_comb begin
    sts.hit    = hit;
    sts.miss   = tok_in && !open_bit;
    sts.empty  = live == '0;
    sts.offset = fit_bump ? bump : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump    <= '0;
      freed   <= '0;
      live    <= '0;
      tok_out <= 1'b0;
    end else begin
      // The token moves on only from an open buffer that could not take the request.
      tok_out <= active && !hit;
      if (hit) begin
        if (fit_bump) begin
          bump <= sum[SIZE_W-1:0];
        end else begin
          bump  <= ctl.req;
          freed <= '0;
        end
        live <= live + LIVE_W'(1);
      end else if (sel) begin
        unique case (ctl.op)
          OP_FREE: begin
            live <= live - LIVE_W'(1);
            if (live == LIVE_W'(1)) begin
              bump  <= '0;
              freed <= '0;
            end else if (ctl.fend > {1'b0, freed}) begin
              freed <= ctl.fend[SIZE_W-1:0];
            end
          end
          OP_INIT: begin
            bump  <= ctl.req;
            freed <= '0;
            live  <= LIVE_W'(1);
          end
          OP_NONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* design/staging_pool_bump_allocator_unit.sv */
// Top level of the staging pool bump allocator: controller, cell row and result register.
//
// Requests arrive on in_ch (valid/ready) as allocate, free or collect; each gives exactly
// one result on out_ch: status, buffer index, offset and the number of open buffers.
// pool_size is written through cfg_we/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce. One request is worked on at a
// time. Allocate sends a search token down the row of buffer cells, one cell per cycle,
// first-fit in index order; the first open cell that fits keeps the token, the token
// reaching an unopened cell opens a new buffer, and the token falling off the row's end
// gives no space. An allocate goes through S_EXEC, S_SEARCH while the token still moves,
// and S_RESP; too big goes from S_EXEC straight to S_RESP. Free goes through S_EXEC and
// S_RESP; collect through S_EXEC, S_COLLECT (closing trailing empty buffers one at a
// time), then S_RESP. A new request is taken after the result enters the output register.
// Reset (rst, synchronous) empties every buffer, sets one buffer open and restores
// pool_size to 268435456. While out_ch is stalled the result is held, and the block
// holds a finished next result until the register frees.
module staging_pool_bump_allocator_unit import spba_pkg::*; #(
  parameter int              MAX_BUFFERS = DEF_MAX_BUFFERS,
  parameter longint unsigned MAX_LIVE    = DEF_MAX_LIVE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  spba_in_if.sink           in_ch,
  spba_out_if.source        out_ch
);

  localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
  localparam int LIVE_W = $clog2(MAX_LIVE + 64'd1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_COLLECT = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [CNT_W-1:0] open;
  logic [CNT_W-1:0] open_next;
  logic [SIZE_W-1:0] pool;

  logic [CMD_W-1:0]  cmd_q;
  logic [SIZE_W-1:0] req_q;
  logic [BIDX_W-1:0] fbuf_q;
  logic [SIZE_W:0]   fend_q;

  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  logic [BIDX_W-1:0]   res_idx;
  logic [BIDX_W-1:0]   res_idx_next;
  logic [SIZE_W-1:0]   res_off;
  logic [SIZE_W-1:0]   res_off_next;
  logic                res_load;

  cell_ctl_t ctl;
  cell_sts_t sts [MAX_BUFFERS];
  logic [MAX_BUFFERS-1:0] sel;
  logic [MAX_BUFFERS-1:0] tok;
  logic [MAX_BUFFERS-1:0] open_mask;
  logic [MAX_BUFFERS-1:0] free_sel;
  logic [MAX_BUFFERS-1:0] init_sel;
  logic [MAX_BUFFERS-1:0] top_sel;
  logic [MAX_BUFFERS-1:0] hit_vec;
  logic [MAX_BUFFERS-1:0] miss_vec;
  logic [MAX_BUFFERS-1:0] empty_vec;
  logic                   tok_start;
  logic                   any_hit;
  logic                   any_miss;
  logic [BIDX_W-1:0]      hit_idx;
  logic [SIZE_W-1:0]      hit_off;
  logic                   too_big;
  logic                   searching;

  genvar g;
  generate
    for (g = 0; g < MAX_BUFFERS; g++) begin : g_cell
      logic tok_in;
      if (g == 0) begin : g_first
        assign tok_in = tok_start;
      end else begin : g_rest
        assign tok_in = tok[g-1];
      end
      spba_cell #(
        .LIVE_W   (LIVE_W),
        .MAX_LIVE (MAX_LIVE)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .sel      (sel[g]),
        .open_bit (open_mask[g]),
        .tok_in   (tok_in),
        .tok_out  (tok[g]),
        .sts      (sts[g])
      );
    end
  endgenerate

  always_comb begin
    hit_idx = '0;
    hit_off = '0;
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      open_mask[i] = int'(open) > i;
      free_sel[i]  = int'(fbuf_q) == i;
      init_sel[i]  = int'(open) == i;
      top_sel[i]   = int'(open) == i + 1;
      hit_vec[i]   = sts[i].hit;
      miss_vec[i]  = sts[i].miss;
      empty_vec[i] = sts[i].empty;
      if (sts[i].hit) begin
        hit_idx = hit_idx | BIDX_W'(i);
        hit_off = hit_off | sts[i].offset;
      end
    end
  end

  // A token falling off the end of the row is a miss as well.
  assign any_hit  = |hit_vec;
  assign any_miss = (|miss_vec) || tok[MAX_BUFFERS-1];
  assign too_big  = req_q > pool;

  always_comb begin
    state_next      = state;
    open_next       = open;
    res_status_next = ST_OK;
    res_idx_next    = '0;
    res_off_next    = '0;
    res_load        = 1'b0;
    tok_start       = 1'b0;
    sel             = '0;
    ctl.op          = OP_NONE;
    ctl.req         = req_q;
    ctl.pool        = pool;
    ctl.fend        = fend_q;
    searching       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_ALLOC: begin
            if (too_big) begin
              res_status_next = ST_TOO_BIG;
              res_load        = 1'b1;
              state_next      = S_RESP;
            end else begin
              tok_start = 1'b1;
              searching = 1'b1;
            end
          end
          CMD_FREE: begin
            priority if (!(|(free_sel & open_mask))) begin
              res_status_next = ST_BAD_INDEX;
            end else if (fend_q > {1'b0, pool}) begin
              res_status_next = ST_PAST_END;
            end else if (|(free_sel & empty_vec)) begin
              res_status_next = ST_NO_LIVE;
            end else begin
              ctl.op = OP_FREE;
              sel    = free_sel;
            end
            res_load   = 1'b1;
            state_next = S_RESP;
          end
          CMD_COLLECT: begin
            state_next = S_COLLECT;
          end
          default: begin
            res_load   = 1'b1;
            state_next = S_RESP;
          end
        endcase
      end
      S_SEARCH: begin
        searching = 1'b1;
      end
      S_COLLECT: begin
        if (open != '0 && (|(top_sel & empty_vec))) begin
          open_next = open - CNT_W'(1);
        end else begin
          res_load   = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (searching) begin
      priority if (any_hit) begin
        res_idx_next = hit_idx;
        res_off_next = hit_off;
        res_load     = 1'b1;
        state_next   = S_RESP;
      end else if (any_miss) begin
        if (open >= CNT_W'(MAX_BUFFERS)) begin
          res_status_next = ST_NO_SPACE;
        end else begin
          ctl.op       = OP_INIT;
          sel          = init_sel;
          open_next    = open + CNT_W'(1);
          res_idx_next = BIDX_W'(open);
        end
        res_load   = 1'b1;
        state_next = S_RESP;
      end else begin
        state_next = S_SEARCH;
      end
    end
  end

  assign in_ch.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      open         <= CNT_W'(1);
      pool         <= POOL_RESET;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      open  <= open_next;
      if (cfg_we) begin
        pool <= cfg_wdata;
      end
      if (state == S_RESP && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_q  <= in_ch.cmd;
      req_q  <= in_ch.req_size;
      fbuf_q <= in_ch.free_buffer;
      fend_q <= {1'b0, in_ch.free_offset} + {1'b0, in_ch.free_length};
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_idx    <= res_idx_next;
      res_off    <= res_off_next;
    end
    if (state == S_RESP && (!out_ch.valid || out_ch.ready)) begin
      out_ch.status         <= res_status;
      out_ch.buffer_index   <= res_idx;
      out_ch.alloc_offset   <= res_off;
      out_ch.buffers_in_use <= USE_W'(open);
    end
  end

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open <= CNT_W'(MAX_BUFFERS))
    else $error("open buffer count exceeds the number of cells");

  a_one_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(hit_vec))
    else $error("more than one cell claimed the search token");

  a_hit_miss: assert property (@(posedge clk) disable iff (rst) !(any_hit && any_miss))
    else $error("search reported a hit and a miss together");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_OK |->
      out_ch.buffer_index == '0 && out_ch.alloc_offset == '0)
    else $error("failed request carries a buffer index or offset");

endmodule
